// ===== sv/tmwf_pkg.sv =====
// Shared constants, types and exit-choice functions of the triangle maze wall follower.
`default_nettype none
package tmwf_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int POS_W     = 7;
  localparam int CFG_W     = 7;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int CELL_W    = 3;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int IN_DW     = 24;
  localparam int OUT_DW    = 16;

  // actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // wall / exit codes
  localparam logic [1:0] EXIT_L  = 2'd0;
  localparam logic [1:0] EXIT_R  = 2'd1;
  localparam logic [1:0] EXIT_TB = 2'd2;

  // result status
  localparam logic [1:0] STAT_IN     = 2'd0;
  localparam logic [1:0] STAT_LEFT   = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  // register index
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1);
  localparam logic [POS_W-1:0] MAX_ROWP = POS_W'(MAX_ROWS);
  localparam logic [POS_W-1:0] MAX_COLP = POS_W'(MAX_COLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_STEP
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic start_commit;
    logic step_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    logic [ROW_IDX_W-1:0] ri;
    logic [COL_IDX_W-1:0] ci;
    ri = ROW_IDX_W'(r - ONE_POS);
    ci = COL_IDX_W'(c - ONE_POS);
    return ADDR_W'(ADDR_W'(ri) * ADDR_W'(MAX_COLS) + ADDR_W'(ci));
  endfunction

  function automatic logic [1:0] pick3(input logic [CELL_W-1:0] code,
                                       input logic [1:0] w0,
                                       input logic [1:0] w1,
                                       input logic [1:0] w2);
    if (!code[w0]) return w0;
    if (!code[w1]) return w1;
    return w2;
  endfunction

  function automatic logic [1:0] choose_exit(input logic [CELL_W-1:0] code,
                                             input logic a,
                                             input logic [1:0] prev);
    logic [1:0] ex;
    case (prev)
      EXIT_R:  ex = a ? pick3(code, EXIT_R, EXIT_TB, EXIT_L)
                      : pick3(code, EXIT_TB, EXIT_R, EXIT_L);
      EXIT_L:  ex = a ? pick3(code, EXIT_TB, EXIT_L, EXIT_R)
                      : pick3(code, EXIT_L, EXIT_TB, EXIT_R);
      default: ex = a ? pick3(code, EXIT_L, EXIT_R, EXIT_TB)
                      : pick3(code, EXIT_R, EXIT_L, EXIT_TB);
    endcase
    return ex;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tmwf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tmwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/tmwf_datapath.sv =====
// Datapath: config registers, cell store, walk state, exit choice and result register.
`default_nettype none
module tmwf_datapath
  import tmwf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status,
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  input  wire logic [1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_DW-1:0]      m_axis_tdata,
  output logic [1:0]             m_axis_tuser,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [CFG_W-1:0]  map_rows, map_cols;
  logic [POS_W-1:0]  eff_rows, eff_cols;
  logic [POS_W-1:0]  cur_row, cur_col, cur_row_next, cur_col_next;
  logic [1:0]        last_exit, last_exit_next;
  logic              rule_hand, rule_hand_next;
  logic              walk_active, walk_active_next;
  logic [POS_W-1:0]  in_row, in_col;
  logic              in_hand;
  logic              out_valid, out_valid_next;
  logic [POS_W-1:0]  out_row, out_col, out_row_next, out_col_next;
  logic [1:0]        out_status, out_status_next;

  logic [POS_W-1:0]  f_row, f_col;
  logic [CELL_W-1:0] f_code;
  logic              f_hand;
  logic              ram_we;
  logic [CELL_W-1:0] cell_code;
  logic              cfg_we;

  logic              start_in, cur_in, new_in;
  logic [1:0]        entry, ex;
  logic              parity;
  logic [POS_W-1:0]  new_row, new_col;

  assign f_row  = s_axis_tdata[POS_W-1:0];
  assign f_col  = s_axis_tdata[2*POS_W-1:POS_W];
  assign f_code = s_axis_tdata[2*POS_W+CELL_W-1:2*POS_W];
  assign f_hand = s_axis_tdata[2*POS_W+CELL_W];

  function automatic logic in_map(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                  input logic [POS_W-1:0] er, input logic [POS_W-1:0] ec);
    return (r >= ONE_POS) && (c >= ONE_POS) && (r <= er) && (c <= ec);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows <= CFG_W'(1);
      map_cols <= CFG_W'(1);
    end else if (cfg_we) begin
      if (paddr[2] == REG_COLS) map_cols <= pwdata[CFG_W-1:0];
      else                      map_rows <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(map_cols) : APB_DW'(map_rows);

  assign eff_rows = (map_rows > MAX_ROWP) ? MAX_ROWP : map_rows;
  assign eff_cols = (map_cols > MAX_COLP) ? MAX_COLP : map_cols;

  // cell store: write on accepted write words in range, read current cell every cycle
  assign ram_we = cmd.accept && (s_axis_tuser == ACT_WRITE) &&
                  (f_row >= ONE_POS) && (f_col >= ONE_POS) &&
                  (f_row <= MAX_ROWP) && (f_col <= MAX_COLP);

  tmwf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_addr(f_row, f_col)),
    .wdata (f_code),
    .raddr (cell_addr(cur_row, cur_col)),
    .rdata (cell_code)
  );

  // hold start operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_row  <= f_row;
      in_col  <= f_col;
      in_hand <= f_hand;
    end
  end

  assign start_in = in_map(in_row, in_col, eff_rows, eff_cols);
  assign cur_in   = in_map(cur_row, cur_col, eff_rows, eff_cols);
  assign parity   = cur_row[0] ^ cur_col[0];
  assign ex       = choose_exit(cell_code, parity ^ rule_hand, last_exit);
  assign new_in   = in_map(new_row, new_col, eff_rows, eff_cols);

  always_comb begin
    new_row = cur_row;
    new_col = cur_col;
    case (ex)
      EXIT_L:  new_col = cur_col - ONE_POS;
      EXIT_R:  new_col = cur_col + ONE_POS;
      default: new_row = parity ? cur_row + ONE_POS : cur_row - ONE_POS;
    endcase
  end

  always_comb begin
    if (in_col == ONE_POS)                            entry = EXIT_R;
    else if (in_col == eff_cols)                      entry = EXIT_L;
    else                                              entry = EXIT_TB;
  end

  always_comb begin
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    last_exit_next   = last_exit;
    rule_hand_next   = rule_hand;
    walk_active_next = walk_active;
    out_valid_next   = out_valid && !m_axis_tready;
    out_row_next     = out_row;
    out_col_next     = out_col;
    out_status_next  = out_status;
    if (cmd.start_commit) begin
      out_valid_next = 1'b1;
      out_row_next   = in_row;
      out_col_next   = in_col;
      if (start_in && (in_col == ONE_POS || in_col == eff_cols ||
                       in_row == ONE_POS || in_row == eff_rows)) begin
        cur_row_next     = in_row;
        cur_col_next     = in_col;
        last_exit_next   = entry;
        rule_hand_next   = in_hand;
        walk_active_next = 1'b1;
        out_status_next  = STAT_IN;
      end else begin
        walk_active_next = 1'b0;
        out_status_next  = STAT_REJECT;
      end
    end else if (cmd.step_commit) begin
      if (!walk_active || !cur_in) begin
        walk_active_next = 1'b0;
      end else begin
        cur_row_next    = new_row;
        cur_col_next    = new_col;
        last_exit_next  = ex;
        out_valid_next  = 1'b1;
        out_row_next    = new_row;
        out_col_next    = new_col;
        if (new_in) begin
          out_status_next = STAT_IN;
        end else begin
          walk_active_next = 1'b0;
          out_status_next  = STAT_LEFT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      last_exit   <= EXIT_L;
      rule_hand   <= 1'b0;
      walk_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      last_exit   <= last_exit_next;
      rule_hand   <= rule_hand_next;
      walk_active <= walk_active_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_row    <= out_row_next;
    out_col    <= out_col_next;
    out_status <= out_status_next;
  end

  assign status.slot_free = !out_valid || m_axis_tready;
  assign m_axis_tvalid    = out_valid;
  assign m_axis_tdata     = {(OUT_DW - 2*POS_W)'(0), out_col, out_row};
  assign m_axis_tuser     = out_status;

  a_leave_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_commit && walk_active && cur_in && !new_in)
      |=> (!walk_active && out_valid && out_status == STAT_LEFT))
    else $error("walk still active after leaving the map");

  a_start_status: assert property (@(posedge clk) disable iff (rst)
    cmd.start_commit |=> (out_valid && ((out_status == STAT_IN) == walk_active)))
    else $error("start result disagrees with walk state");

endmodule
`default_nettype wire

// ===== sv/tmwf_ctrl.sv =====
// Controller: sequences accept, start and step commits.
`default_nettype none
module tmwf_ctrl
  import tmwf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  input  wire logic [1:0] s_axis_tuser,
  output logic            s_axis_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == ACT_START)     state_next = ST_START;
          else if (s_axis_tuser == ACT_STEP) state_next = ST_STEP;
        end
      end
      ST_START, ST_STEP: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready    = (state == ST_IDLE);
    cmd.accept       = (state == ST_IDLE) && s_axis_tvalid;
    cmd.start_commit = (state == ST_START) && status.slot_free;
    cmd.step_commit  = (state == ST_STEP) && status.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  a_step_reads: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && s_axis_tuser == ACT_STEP) |=> (state == ST_STEP))
    else $error("step word did not enter the step state");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && !status.slot_free) |=> (state == ST_STEP && !s_axis_tready))
    else $error("step dropped while result slot busy");

endmodule
`default_nettype wire

// ===== sv/triangle_maze_wall_follower_unit.sv =====
// Top level of the triangle maze wall follower.
//
// Usage: load the maze through the input stream with write words (tuser = 0),
// one 3-bit wall code per cell, after setting map_rows/map_cols over APB.
// A start word (tuser = 1) checks the start cell, picks the entry side and
// returns the start position; each step word (tuser = 2) in an active walk
// reads the current cell, picks the exit wall by the hand rule and returns
// the new position, status 1 once the walk has left the map. Unknown words
// are dropped. Write words produce no result. Start and step words wait in
// a start or step state for their commit: the step's cell read goes through the
// registered read port of the cell RAM, and the next step needs the position
// this one writes back. A result is valid in the cycle after the commit.
// The result register frees the input side: a new word is taken while a result
// waits, but a start or step commit holds until the result slot is free.
// Reset (synchronous) clears the walk state and sets both sizes to 1; the cell
// RAM is not cleared and must be written before it is walked.
`default_nettype none
module triangle_maze_wall_follower_unit
  import tmwf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_DW-1:0]  s_axis_tdata,  // row[6:0], col[13:7], cell_code[16:14], hand[17]
  input  wire logic [1:0]        s_axis_tuser,  // action[1:0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_DW-1:0]      m_axis_tdata,  // pos_row[6:0], pos_col[13:7]
  output logic [1:0]             m_axis_tuser,  // status[1:0]
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tmwf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  tmwf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

endmodule
`default_nettype wire
